### design/stgp_pkg.sv
// Shared types, constants and counter update and prediction functions of the split-table gshare predictor.
package stgp_pkg;

	localparam int unsigned DEF_INDEX_BITS = 12;
	localparam int unsigned ADDR_BITS = 32;
	localparam int unsigned COUNT_BITS = 32;
	localparam int unsigned CTR_BITS = 2;

	typedef logic [CTR_BITS-1:0] ctr_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] branch_address;
		logic                 taken;
		logic                 hard_branch;
	} branch_t;

	typedef struct packed {
		logic                  predicted_taken;
		logic                  mispredicted;
		logic [COUNT_BITS-1:0] mispredict_count;
		logic [COUNT_BITS-1:0] prediction_count;
	} result_t;

	localparam ctr_t CTR_STRONG_NOT = 2'd0;
	localparam ctr_t CTR_WEAK_NOT   = 2'd1;
	localparam ctr_t CTR_WEAK_TAKEN = 2'd2;
	localparam ctr_t CTR_STRONG     = 2'd3;

	function automatic ctr_t next_counter(input ctr_t ctr, input logic went);
		ctr_t nxt;
		unique case (ctr)
			CTR_STRONG_NOT: nxt = went ? CTR_WEAK_NOT : CTR_STRONG_NOT;
			CTR_WEAK_NOT:   nxt = went ? CTR_STRONG : CTR_STRONG_NOT;
			CTR_WEAK_TAKEN: nxt = went ? CTR_STRONG : CTR_STRONG_NOT;
			CTR_STRONG:     nxt = went ? CTR_STRONG : CTR_WEAK_TAKEN;
			default:        nxt = CTR_STRONG_NOT;
		endcase
		return nxt;
	endfunction

	function automatic logic predicts_taken(input ctr_t ctr);
		return ctr[CTR_BITS-1];
	endfunction

endpackage

### design/stgp_ctr_ram.sv
// Counter table: one write port and one registered read port.
module stgp_ctr_ram #(
	parameter int unsigned INDEX_BITS = stgp_pkg::DEF_INDEX_BITS
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [INDEX_BITS-1:0] waddr,
	input  stgp_pkg::ctr_t        wdata,
	input  logic                  re,
	input  logic [INDEX_BITS-1:0] raddr,
	output stgp_pkg::ctr_t        rdata
);

	localparam int unsigned DEPTH = 1 << INDEX_BITS;

	stgp_pkg::ctr_t mem [DEPTH];
	stgp_pkg::ctr_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/split_table_gshare_predictor.sv
// Top level of the split-table gshare branch predictor.
// One resolved branch is taken per cycle while branch_stall is low; it passes through the table
// stage and the result register. The two counter tables are synchronous memories read on
// acceptance and written back when the table stage advances, with the last write forwarded to
// the following beat. After reset the block clears both tables, one entry per cycle, and holds
// branch_stall high until every entry is cleared. While a result beat is stalled and another
// item waits in the table stage, branch_stall follows result_stall in the same cycle.
module split_table_gshare_predictor #(
	parameter int unsigned INDEX_BITS = stgp_pkg::DEF_INDEX_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              branch_valid,
	output logic              branch_stall,
	input  stgp_pkg::branch_t branch,
	output logic              result_valid,
	input  logic              result_stall,
	output stgp_pkg::result_t result
);

	localparam int unsigned CB = stgp_pkg::COUNT_BITS;

	logic                  clr_q;
	logic [INDEX_BITS-1:0] clr_idx_q;
	logic [INDEX_BITS-1:0] hist_q;

	logic                  s1_valid_q;
	logic [INDEX_BITS-1:0] idx_s1;
	logic                  taken_s1;
	logic                  hard_s1;

	logic                  fwd_valid_q;
	logic                  fwd_hard_q;
	logic [INDEX_BITS-1:0] fwd_idx_q;
	stgp_pkg::ctr_t        fwd_ctr_q;

	logic [CB-1:0]         miss_total_q;
	logic [CB-1:0]         branch_total_q;

	logic                  out_valid_q;
	stgp_pkg::result_t     out_q;

	logic                  accept;
	logic                  s1_adv;
	logic [INDEX_BITS-1:0] rd_idx;
	stgp_pkg::ctr_t        easy_rdata;
	stgp_pkg::ctr_t        hard_rdata;
	stgp_pkg::ctr_t        ctr;
	stgp_pkg::ctr_t        ctr_next;
	logic                  pred;
	logic                  miss;
	logic [CB-1:0]         miss_total_next;
	logic [CB-1:0]         branch_total_next;
	logic                  easy_we;
	logic                  hard_we;
	logic [INDEX_BITS-1:0] waddr;
	stgp_pkg::ctr_t        wdata;

	assign s1_adv       = s1_valid_q && (!out_valid_q || !result_stall);
	assign branch_stall = clr_q || (s1_valid_q && !s1_adv);
	assign accept       = branch_valid && !branch_stall;
	assign rd_idx       = branch.branch_address[INDEX_BITS-1:0] ^ hist_q;

	always_comb begin
		ctr = hard_s1 ? hard_rdata : easy_rdata;
		if (fwd_valid_q && (fwd_hard_q == hard_s1) && (fwd_idx_q == idx_s1)) begin
			ctr = fwd_ctr_q;
		end
	end

	assign ctr_next = stgp_pkg::next_counter(ctr, taken_s1);
	assign pred     = stgp_pkg::predicts_taken(ctr);
	assign miss     = pred != taken_s1;

	assign miss_total_next   = (miss && (miss_total_q != '1)) ?
		CB'(miss_total_q + 1'b1) : miss_total_q;
	assign branch_total_next = (branch_total_q != '1) ?
		CB'(branch_total_q + 1'b1) : branch_total_q;

	assign easy_we = clr_q || (s1_adv && !hard_s1);
	assign hard_we = clr_q || (s1_adv && hard_s1);
	assign waddr   = clr_q ? clr_idx_q : idx_s1;
	assign wdata   = clr_q ? stgp_pkg::CTR_STRONG_NOT : ctr_next;

	stgp_ctr_ram #(
		.INDEX_BITS(INDEX_BITS)
	) u_easy_ram (
		.clk  (clk),
		.we   (easy_we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (accept),
		.raddr(rd_idx),
		.rdata(easy_rdata)
	);

	stgp_ctr_ram #(
		.INDEX_BITS(INDEX_BITS)
	) u_hard_ram (
		.clk  (clk),
		.we   (hard_we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (accept),
		.raddr(rd_idx),
		.rdata(hard_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q          <= 1'b1;
			clr_idx_q      <= '0;
			hist_q         <= '0;
			s1_valid_q     <= 1'b0;
			fwd_valid_q    <= 1'b0;
			miss_total_q   <= '0;
			branch_total_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= INDEX_BITS'(clr_idx_q + 1'b1);
				if (clr_idx_q == '1) begin
					clr_q <= 1'b0;
				end
			end
			if (accept && branch.hard_branch) begin
				hist_q <= {hist_q[INDEX_BITS-2:0], branch.taken};
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				fwd_valid_q    <= 1'b1;
				miss_total_q   <= miss_total_next;
				branch_total_q <= branch_total_next;
				out_valid_q    <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1   <= rd_idx;
			taken_s1 <= branch.taken;
			hard_s1  <= branch.hard_branch;
		end
		if (s1_adv) begin
			fwd_hard_q                <= hard_s1;
			fwd_idx_q                 <= idx_s1;
			fwd_ctr_q                 <= ctr_next;
			out_q.predicted_taken     <= pred;
			out_q.mispredicted        <= miss;
			out_q.mispredict_count    <= miss_total_next;
			out_q.prediction_count    <= branch_total_next;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> branch_stall)
		else $error("branch accepted during table clearing");

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> (result_valid && result.prediction_count == branch_total_q))
		else $error("table stage advanced without a matching result beat");

	a_total_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && branch_total_q != '1) |=>
		branch_total_q == CB'($past(branch_total_q) + 1'b1))
		else $error("branch total did not step by one");

	a_history_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && branch.hard_branch) |=>
		hist_q == {$past(hist_q[INDEX_BITS-2:0]), $past(branch.taken)})
		else $error("global history not shifted on a hard branch");

endmodule
